// ===== design/bdp_pkg.sv =====
// Shared constants and types for the blockwise difference predictor.
// Used by blockwise_difference_predictor_top; depends on nothing else.
package bdp_pkg;

   // Default sizing of the stage cascade and of the internal sample arithmetic.
   localparam int MAX_ORDER_DEFAULT   = 8;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Fixed field widths of the ports.
   localparam int PORT_SAMPLE_BITS = 16;
   localparam int ORDER_BITS       = 4;
   localparam int BLOCK_LEN_BITS   = 16;
   localparam int CSR_DATA_BITS    = 16;
   localparam int CSR_INDEX_BITS   = 2;

   // Register values after reset.
   localparam logic [ORDER_BITS-1:0]     PRED_ORDER_RESET   = '0;
   localparam logic [BLOCK_LEN_BITS-1:0] BLOCK_LEN_RESET    = 16'd1024;
   localparam logic                      DECODE_MODE_RESET  = 1'b0;
   localparam logic                      STEREO_DECOR_RESET = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PRED_ORDER   = 2'd0,
      CSR_BLOCK_LENGTH = 2'd1,
      CSR_DECODE_MODE  = 2'd2,
      CSR_STEREO_DECOR = 2'd3
   } csr_index_type;

endpackage

// ===== design/blockwise_difference_predictor_top.sv =====
// Blockwise difference predictor: stereo decorrelation plus a cascade of
// difference (encode) or integrator (decode) stages that restart per block.
// Depends on bdp_pkg.
//
// Usage:
//   Input channel req_*: one stereo frame per transfer (main sample, second
//   sample, stream_start). Result channel rsp_*: one frame per input frame,
//   in order, with rsp_block_begins marking the first frame of each block.
//   Configuration port csr_*: one register written per cycle with csr_write
//   high; write it only while no frame is in flight.
//   Path: a transferred frame waits in the input register and moves into the
//   result register, which drives rsp_*, once that register can take it.
//   Throughput: one frame per cycle unless rsp_stall holds a full result
//   register. The input register feeds a single pass of chained SAMPLE_BITS
//   adders (up to MAX_ORDER stages per channel plus the channel add) into the
//   result register, and the stage memories update as a frame moves into it.
//   A frame is accepted while a finished result still waits to be taken; when
//   rsp_stall holds and both registers are full, req_stall rises in the same
//   cycle and the frame registers, stage memories and block position hold.
//   Reset clears both valid flags, the stage memories, the block position and
//   the configuration registers (order 0, block length 1024, encode mode,
//   stereo decorrelation on).
module blockwise_difference_predictor_top #(
   parameter int MAX_ORDER   = bdp_pkg::MAX_ORDER_DEFAULT,
   parameter int SAMPLE_BITS = bdp_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // input channel
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [bdp_pkg::PORT_SAMPLE_BITS-1:0] req_main_sample,
   input  logic signed [bdp_pkg::PORT_SAMPLE_BITS-1:0] req_second_sample,
   input  logic                                        req_stream_start,
   // result channel
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [bdp_pkg::PORT_SAMPLE_BITS-1:0] rsp_main_out,
   output logic signed [bdp_pkg::PORT_SAMPLE_BITS-1:0] rsp_second_out,
   output logic                                        rsp_block_begins,
   // configuration port
   input  logic                                        csr_write,
   input  bdp_pkg::csr_index_type                      csr_index,
   input  logic [bdp_pkg::CSR_DATA_BITS-1:0]           csr_wdata
);
   import bdp_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Configuration registers.
   logic [ORDER_BITS-1:0]     pred_order_ff,   pred_order_in;
   logic [BLOCK_LEN_BITS-1:0] block_len_ff,    block_len_in;
   logic                      decode_mode_ff,  decode_mode_in;
   logic                      stereo_ff,       stereo_in;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   sample_type in_main_ff,  in_main_in;
   sample_type in_second_ff, in_second_in;
   logic       in_start_ff, in_start_in;

   // Result register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [PORT_SAMPLE_BITS-1:0] rsp_main_ff,  rsp_main_in;
   logic signed [PORT_SAMPLE_BITS-1:0] rsp_second_ff, rsp_second_in;
   logic                               rsp_first_ff, rsp_first_in;

   // Stage memories and block position.
   sample_type                main_mem_ff   [MAX_ORDER];
   sample_type                main_mem_in   [MAX_ORDER];
   sample_type                second_mem_ff [MAX_ORDER];
   sample_type                second_mem_in [MAX_ORDER];
   logic [BLOCK_LEN_BITS-1:0] position_ff, position_in;

   // Handshake and datapath signals.
   logic                      accept;
   logic                      advance;
   logic                      out_ready;
   logic [BLOCK_LEN_BITS-1:0] pos_now;
   logic [BLOCK_LEN_BITS:0]   pos_inc;
   logic                      first;
   sample_type                main_val;
   sample_type                second_val;
   sample_type                second_res;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   // Configuration writes.
   always_comb begin
      pred_order_in  = pred_order_ff;
      block_len_in   = block_len_ff;
      decode_mode_in = decode_mode_ff;
      stereo_in      = stereo_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PRED_ORDER:   pred_order_in  = csr_wdata[ORDER_BITS-1:0];
            CSR_BLOCK_LENGTH: block_len_in   = csr_wdata[BLOCK_LEN_BITS-1:0];
            CSR_DECODE_MODE:  decode_mode_in = csr_wdata[0];
            CSR_STEREO_DECOR: stereo_in      = csr_wdata[0];
            default: begin
               pred_order_in = pred_order_ff;
            end
         endcase
      end
   end

   // Input register: the size cast sign-extends or cuts to the internal width.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_main_in   = in_main_ff;
      in_second_in = in_second_ff;
      in_start_in  = in_start_ff;
      if (accept) begin
         in_valid_in  = 1'b1;
         in_main_in   = SAMPLE_BITS'(req_main_sample);
         in_second_in = SAMPLE_BITS'(req_second_sample);
         in_start_in  = req_stream_start;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Block framing.
   always_comb begin
      pos_now = in_start_ff ? '0 : position_ff;
      first   = (pos_now == '0);
      pos_inc = {1'b0, pos_now} + (BLOCK_LEN_BITS+1)'(1);
      position_in = position_ff;
      if (advance) begin
         if (block_len_ff == '0) begin
            position_in = pos_inc[BLOCK_LEN_BITS-1:0];
         end else if (pos_inc >= {1'b0, block_len_ff}) begin
            position_in = '0;
         end else begin
            position_in = pos_inc[BLOCK_LEN_BITS-1:0];
         end
      end
   end

   // Stage cascade. At a block start each active stage only loads its memory
   // and passes the value through. Stages at or beyond the order are idle.
   always_comb begin
      sample_type diff;
      main_val   = in_main_ff;
      second_val = in_second_ff;
      diff       = '0;
      if (!decode_mode_ff && stereo_ff) begin
         second_val = in_second_ff - in_main_ff;
      end
      for (int k = 0; k < MAX_ORDER; k++) begin
         main_mem_in[k]   = main_mem_ff[k];
         second_mem_in[k] = second_mem_ff[k];
         if (advance && (ORDER_BITS'(k) < pred_order_ff)) begin
            if (first) begin
               main_mem_in[k]   = main_val;
               second_mem_in[k] = second_val;
            end else if (decode_mode_ff) begin
               main_val         = main_val + main_mem_ff[k];
               second_val       = second_val + second_mem_ff[k];
               main_mem_in[k]   = main_val;
               second_mem_in[k] = second_val;
            end else begin
               main_mem_in[k]   = main_val;
               second_mem_in[k] = second_val;
               diff             = main_val - main_mem_ff[k];
               main_val         = diff;
               diff             = second_val - second_mem_ff[k];
               second_val       = diff;
            end
         end
      end
      second_res = second_val;
      if (decode_mode_ff && stereo_ff) begin
         second_res = second_val + main_val;
      end
   end

   // Result register.
   always_comb begin
      rsp_main_in   = rsp_main_ff;
      rsp_second_in = rsp_second_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in  = 1'b1;
         rsp_main_in   = PORT_SAMPLE_BITS'(main_val);
         rsp_second_in = PORT_SAMPLE_BITS'(second_res);
         rsp_first_in  = first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_order_ff  <= PRED_ORDER_RESET;
         block_len_ff   <= BLOCK_LEN_RESET;
         decode_mode_ff <= DECODE_MODE_RESET;
         stereo_ff      <= STEREO_DECOR_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         position_ff    <= '0;
         for (int k = 0; k < MAX_ORDER; k++) begin
            main_mem_ff[k]   <= '0;
            second_mem_ff[k] <= '0;
         end
      end else begin
         pred_order_ff  <= pred_order_in;
         block_len_ff   <= block_len_in;
         decode_mode_ff <= decode_mode_in;
         stereo_ff      <= stereo_in;
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         position_ff    <= position_in;
         for (int k = 0; k < MAX_ORDER; k++) begin
            main_mem_ff[k]   <= main_mem_in[k];
            second_mem_ff[k] <= second_mem_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      in_main_ff    <= in_main_in;
      in_second_ff  <= in_second_in;
      in_start_ff   <= in_start_in;
      rsp_main_ff   <= rsp_main_in;
      rsp_second_ff <= rsp_second_in;
      rsp_first_ff  <= rsp_first_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_main_out     = rsp_main_ff;
   assign rsp_second_out   = rsp_second_ff;
   assign rsp_block_begins = rsp_first_ff;

   // The input side only stalls when a frame is waiting in the input register.
   a_stall_needs_frame: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall raised with an empty input register");

   // After a frame moves on, the position stays below a nonzero block length.
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      (advance && block_len_ff != '0) |=> (position_ff < $past(block_len_ff)))
      else $error("block position ran past the block length");

   // A stream start always yields a block-start result.
   a_start_marks_block: assert property (@(posedge clock) disable iff (reset)
      (advance && in_start_ff) |=> (rsp_valid && rsp_block_begins))
      else $error("stream start did not produce a block start");

   // A new result only appears after a frame left the input register.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff))
      else $error("result appeared without a frame in the input register");

   // With no active stages the main channel passes through unchanged.
   a_order_zero_pass: assert property (@(posedge clock) disable iff (reset)
      (advance && pred_order_ff == '0)
         |=> (rsp_main_out == PORT_SAMPLE_BITS'($past(in_main_ff))))
      else $error("main channel altered with prediction order zero");

endmodule

// ===== bench/tb_blockwise_difference_predictor_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for blockwise_difference_predictor_top: a bursty frame driver,
// a stalling result monitor and a frame-level predictor of the stage cascade.
// Depends on bdp_pkg and the block under test.
module tb_blockwise_difference_predictor_top;
   import bdp_pkg::*;

   localparam int STAGES      = MAX_ORDER_DEFAULT;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic signed [PORT_SAMPLE_BITS-1:0] main_sample;
      logic signed [PORT_SAMPLE_BITS-1:0] second_sample;
      logic                               stream_start;
   } stereo_frame_type;

   typedef struct packed {
      logic signed [PORT_SAMPLE_BITS-1:0] main_out;
      logic signed [PORT_SAMPLE_BITS-1:0] second_out;
      logic                               block_begins;
   } coded_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [PORT_SAMPLE_BITS-1:0] req_main_sample = '0;
   logic signed [PORT_SAMPLE_BITS-1:0] req_second_sample = '0;
   logic                               req_stream_start = 1'b0;

   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [PORT_SAMPLE_BITS-1:0] rsp_main_out;
   logic signed [PORT_SAMPLE_BITS-1:0] rsp_second_out;
   logic                               rsp_block_begins;

   logic                     csr_write = 1'b0;
   csr_index_type            csr_index = CSR_PRED_ORDER;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   blockwise_difference_predictor_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_main_sample   (req_main_sample),
      .req_second_sample (req_second_sample),
      .req_stream_start  (req_stream_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_main_out      (rsp_main_out),
      .rsp_second_out    (rsp_second_out),
      .rsp_block_begins  (rsp_block_begins),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the configuration and of the stage memories.
   logic [ORDER_BITS-1:0]           cfg_order;
   logic [BLOCK_LEN_BITS-1:0]       cfg_block_length;
   logic                            cfg_decode;
   logic                            cfg_stereo;
   logic [PORT_SAMPLE_BITS-1:0]     stage_mem [2][STAGES];
   logic [BLOCK_LEN_BITS-1:0]       block_pos;

   stereo_frame_type pending_frames[$];
   coded_frame_type  expected_frames[$];
   stereo_frame_type offered;
   int               frames_submitted = 0;
   int               frames_accepted = 0;
   int               frames_checked = 0;
   int               error_count = 0;

   // Runs one channel through the difference or integrator cascade.
   function automatic logic [PORT_SAMPLE_BITS-1:0] run_cascade(int ch,
         logic [PORT_SAMPLE_BITS-1:0] v, int n, bit opens_block);
      logic [PORT_SAMPLE_BITS-1:0] d;
      for (int k = 0; k < n; k++) begin
         if (opens_block) begin
            stage_mem[ch][k] = v;
         end else if (cfg_decode) begin
            v = v + stage_mem[ch][k];
            stage_mem[ch][k] = v;
         end else begin
            d = v - stage_mem[ch][k];
            stage_mem[ch][k] = v;
            v = d;
         end
      end
      return v;
   endfunction

   function automatic coded_frame_type predict_frame(stereo_frame_type f);
      coded_frame_type             r;
      logic [PORT_SAMPLE_BITS-1:0] m;
      logic [PORT_SAMPLE_BITS-1:0] s;
      logic [BLOCK_LEN_BITS-1:0]   pos;
      int                          n;
      int                          nxt;
      bit                          opens_block;
      m = f.main_sample;
      s = f.second_sample;
      n = (cfg_order > STAGES) ? STAGES : int'(cfg_order);
      pos = f.stream_start ? '0 : block_pos;
      opens_block = (pos == 0);
      if (!cfg_decode && cfg_stereo) s = s - m;
      m = run_cascade(0, m, n, opens_block);
      s = run_cascade(1, s, n, opens_block);
      if (cfg_decode && cfg_stereo) s = s + m;
      nxt = int'(pos) + 1;
      if (cfg_block_length == 0) nxt = nxt % 65536;
      else if (nxt >= int'(cfg_block_length)) nxt = 0;
      block_pos = 16'(nxt);
      r.main_out = m;
      r.second_out = s;
      r.block_begins = opens_block;
      return r;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int gap_left = 0;
   int burst_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
         burst_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_frames = {expected_frames, predict_frame(offered)};
            frames_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_frames.size() > 0) begin
               offered = pending_frames.pop_front();
               req_valid <= 1'b1;
               req_main_sample <= offered.main_sample;
               req_second_sample <= offered.second_sample;
               req_stream_start <= offered.stream_start;
               if (burst_left > 0) begin
                  burst_left--;
               end else if ($urandom_range(0, 9) < 3) begin
                  // A long stretch with no idle cycles at all.
                  burst_left = $urandom_range(40, 200);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = $urandom_range(0, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each transfer and stalls on its own changing pattern.
   int hold_left = 0;
   int pattern_left = 0;
   int pattern_kind = 0;
   coded_frame_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected result main %0d second %0d begins %0b", $time,
                        rsp_main_out, rsp_second_out, rsp_block_begins);
               error_count++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_main_out !== want.main_out) begin
                  $display("%0t: main_out expected %0d, got %0d", $time, want.main_out,
                           rsp_main_out);
                  error_count++;
               end
               if (rsp_second_out !== want.second_out) begin
                  $display("%0t: second_out expected %0d, got %0d", $time, want.second_out,
                           rsp_second_out);
                  error_count++;
               end
               if (rsp_block_begins !== want.block_begins) begin
                  $display("%0t: block_begins expected %0b, got %0b", $time,
                           want.block_begins, rsp_block_begins);
                  error_count++;
               end
            end
            frames_checked++;
            // Hold off well inside the first random phase so that the block backs up.
            if (frames_checked == 50) hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (pattern_left == 0) begin
               pattern_kind = $urandom_range(0, 3);
               pattern_left = $urandom_range(16, 96);
               if ($urandom_range(0, 19) == 0) hold_left = $urandom_range(20, 80);
            end
            pattern_left--;
            case (pattern_kind)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 25);
               2: rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= (pattern_left % 3) != 0;
            endcase
         end
      end
   end

   // Watchdog on cycles without any transfer or register write.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic add_frame(logic [15:0] m, logic [15:0] s, logic st);
      stereo_frame_type f;
      f.main_sample = m;
      f.second_sample = s;
      f.stream_start = st;
      pending_frames = {pending_frames, f};
      frames_submitted++;
   endtask

   // Updates the predictor copy and drives one register write; leaves csr_write high for the caller to lower.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_PRED_ORDER:   cfg_order = value[ORDER_BITS-1:0];
         CSR_BLOCK_LENGTH: cfg_block_length = value;
         CSR_DECODE_MODE:  cfg_decode = value[0];
         default:          cfg_stereo = value[0];
      endcase
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (frames_accepted != frames_submitted || expected_frames.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   logic [15:0] walk_main;
   logic [15:0] walk_second;
   int          random_frames;
   int          phase_frames;
   int          step;
   int          pick;
   bit          tidy;
   bit          first_phase;

   initial begin
      cfg_order = PRED_ORDER_RESET;
      cfg_block_length = BLOCK_LEN_RESET;
      cfg_decode = DECODE_MODE_RESET;
      cfg_stereo = STEREO_DECOR_RESET;
      block_pos = '0;
      for (int k = 0; k < STAGES; k++) begin
         stage_mem[0][k] = '0;
         stage_mem[1][k] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: order zero, encode, stereo step on; extremes wrap.
      add_frame(16'sh7FFF, 16'sh8000, 1'b1);
      add_frame(16'sh8000, 16'sh7FFF, 1'b0);
      add_frame(16'sh0000, 16'shFFFF, 1'b0);
      wait_drained();

      // Order above the cascade depth saturates; short blocks and a stream start mid-block.
      write_reg(CSR_PRED_ORDER, 16'd15);
      write_reg(CSR_BLOCK_LENGTH, 16'd5);
      csr_write <= 1'b0;
      add_frame(16'sd100, 16'sd200, 1'b0);
      add_frame(16'sh8000, 16'sh7FFF, 1'b0);
      add_frame(16'sh7FFF, 16'sh8000, 1'b0);
      add_frame(16'sd5, 16'sd5, 1'b1);
      add_frame(16'sd1, 16'shFFFF, 1'b0);
      add_frame(16'shFFFF, 16'sd1, 1'b0);
      wait_drained();

      // Zero block length: the position only wraps at the counter width.
      write_reg(CSR_PRED_ORDER, 16'd3);
      write_reg(CSR_BLOCK_LENGTH, 16'd0);
      csr_write <= 1'b0;
      add_frame(16'sd1000, -16'sd1000, 1'b0);
      add_frame(16'sd1200, -16'sd900, 1'b0);
      add_frame(16'sd1500, -16'sd700, 1'b0);
      add_frame(16'sd1400, -16'sd800, 1'b0);
      wait_drained();

      // Length lowered below the current position and order raised mid-block.
      write_reg(CSR_BLOCK_LENGTH, 16'd2);
      write_reg(CSR_PRED_ORDER, 16'd6);
      csr_write <= 1'b0;
      add_frame(16'sd300, 16'sd301, 1'b0);
      add_frame(16'sd310, 16'sd320, 1'b0);
      add_frame(16'sd330, 16'sd290, 1'b0);
      add_frame(-16'sd50, 16'sd70, 1'b0);
      wait_drained();

      // Decode mode with and without the stereo step.
      write_reg(CSR_DECODE_MODE, 16'd1);
      write_reg(CSR_STEREO_DECOR, 16'd0);
      write_reg(CSR_PRED_ORDER, 16'd8);
      write_reg(CSR_BLOCK_LENGTH, 16'd3);
      csr_write <= 1'b0;
      add_frame(16'sd7, -16'sd7, 1'b1);
      add_frame(16'sh7FFF, 16'sh8000, 1'b0);
      add_frame(16'sd1, 16'shFFFF, 1'b0);
      add_frame(16'sh8000, 16'sd2, 1'b0);
      wait_drained();
      write_reg(CSR_STEREO_DECOR, 16'd1);
      csr_write <= 1'b0;
      add_frame(16'sh4000, 16'sh4000, 1'b1);
      add_frame(16'sh3FFF, 16'shC000, 1'b0);
      add_frame(-16'sd3, 16'sd9, 1'b0);
      add_frame(16'sd0, 16'sd0, 1'b0);
      wait_drained();

      random_frames = 0;
      first_phase = 1'b1;
      walk_main = '0;
      walk_second = '0;
      while (random_frames < 600) begin
         if (first_phase || $urandom_range(0, 9) < 6) begin
            write_reg(CSR_PRED_ORDER, 16'($urandom_range(0, 9) < 8 ?
                      $urandom_range(0, 8) : $urandom_range(9, 15)));
         end
         if (first_phase || $urandom_range(0, 9) < 6) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)      write_reg(CSR_BLOCK_LENGTH, 16'd1);
            else if (pick < 25) write_reg(CSR_BLOCK_LENGTH, 16'd65535);
            else if (pick < 30) write_reg(CSR_BLOCK_LENGTH, 16'd0);
            else if (pick < 40) write_reg(CSR_BLOCK_LENGTH, 16'($urandom_range(41, 2000)));
            else                write_reg(CSR_BLOCK_LENGTH, 16'($urandom_range(2, 40)));
         end
         if (first_phase || $urandom_range(0, 9) < 5) begin
            write_reg(CSR_DECODE_MODE, 16'($urandom_range(0, 1)));
         end
         if (first_phase || $urandom_range(0, 9) < 5) begin
            write_reg(CSR_STEREO_DECOR, 16'($urandom_range(0, 1)));
         end
         csr_write <= 1'b0;

         phase_frames = first_phase ? 120 : $urandom_range(20, 120);
         tidy = first_phase || ($urandom_range(0, 9) < 7);
         step = $urandom_range(1, 2000);
         for (int i = 0; i < phase_frames; i++) begin
            if (tidy) begin
               // Correlated channels that move in small steps, now and then a wild frame.
               walk_main = walk_main + 16'($urandom_range(0, 2 * step) - step);
               walk_second = walk_main + 16'($urandom_range(0, 2 * step) - step);
               if ($urandom_range(0, 99) < 15) begin
                  add_frame(16'($urandom), 16'($urandom), i == 0);
               end else begin
                  add_frame(walk_main, walk_second,
                            (i == 0) || ($urandom_range(0, 49) == 0));
               end
            end else begin
               add_frame(16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0);
            end
         end
         random_frames += phase_frames;
         first_phase = 1'b0;
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_frames.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/bdp_pkg.sv
design/blockwise_difference_predictor_top.sv
bench/tb_blockwise_difference_predictor_top.sv
